### rtl/core/ncsn_pkg.sv
package ncsn_pkg;

    // fixed-point format and class counts
    localparam int FRAC_BITS    = 16;
    localparam int NUM_CLASSES  = 9;
    localparam int NUM_EXON     = 6;
    localparam int NUM_GROUPS   = 3;
    localparam int GROUP_SIZE   = NUM_CLASSES / NUM_GROUPS;
    localparam int SCORE_W      = 32;
    localparam int NORM_W       = FRAC_BITS + 1;

    // exponent unit widths
    localparam int E_W          = SCORE_W + 1;
    localparam int BIG_W        = 2 * SCORE_W - FRAC_BITS;
    localparam int N_MAX        = 33;
    localparam int N_W          = 6;
    localparam int TAYLOR_TERMS = 12;
    localparam int RECIP_W      = 34;

    // sums and divider widths
    localparam int SUM3_W       = E_W + 2;
    localparam int DEN_W        = E_W + 4;
    localparam int NUM_W        = E_W + FRAC_BITS + 1;
    localparam int CMP_W        = DEN_W + NORM_W + 1;

    // stream widths
    localparam int IN_W         = NUM_CLASSES * SCORE_W;
    localparam int OUT_W        = ((NUM_CLASSES * NORM_W + 7) / 8) * 8;

    // pipeline depth of each part
    localparam int EXT_LAT      = 3;
    localparam int EXP_LAT      = 2 * TAYLOR_TERMS + 3;
    localparam int SUM_LAT      = 2;
    localparam int DIV_LAT      = NORM_W + 2;
    localparam int PIPE_LAT     = EXT_LAT + EXP_LAT + SUM_LAT + DIV_LAT;

    localparam logic [SCORE_W-1:0] LN2_Q32 = 32'hB17217F8;
    localparam logic [E_W-1:0]     ONE_Q32 = {1'b1, {SCORE_W{1'b0}}};
    localparam logic [NORM_W-1:0]  NORM_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_CLASS  = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SEL_ROUND = 2'd0,
        SEL_DIV   = 2'd1,
        SEL_ZERO  = 2'd2
    } sel_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
    } ctl_t;

    typedef struct packed {
        logic [E_W-1:0]    e;
        logic [DEN_W-1:0]  den;
        sel_t              sel;
        logic [NORM_W-1:0] rnd;
    } div_in_t;

    typedef logic [NUM_CLASSES-1:0][SCORE_W-1:0] score_vec_t;

    // ceil(2^(32+l)/k) with l = ceil(log2 k): exact floor division of 32-bit values
    function automatic logic [RECIP_W-1:0] recip_mult(input int k);
        logic [RECIP_W-1:0] m;
        unique case (k)
            3, 6, 12: m = 34'd5726623062;
            5, 10:    m = 34'd6871947674;
            7:        m = 34'd4908534053;
            9:        m = 34'd7635497416;
            11:       m = 34'd6247225158;
            default:  m = 34'd4294967296;
        endcase
        return m;
    endfunction

    function automatic int recip_shift(input int k);
        int s;
        unique case (k)
            1:                 s = 32;
            2:                 s = 33;
            3, 4:              s = 34;
            5, 6, 7, 8:        s = 35;
            default:           s = 36;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/ncsn_extrema.sv
module ncsn_extrema (
    input  logic                 aclk,
    input  logic                 en,
    input  ncsn_pkg::mode_t      mode,
    input  ncsn_pkg::score_vec_t scores,
    output ncsn_pkg::score_vec_t delta
);

    logic signed [ncsn_pkg::SCORE_W-1:0] s1_reg [0:ncsn_pkg::NUM_CLASSES-1];
    logic signed [ncsn_pkg::SCORE_W-1:0] s2_reg [0:ncsn_pkg::NUM_CLASSES-1];
    logic signed [ncsn_pkg::SCORE_W-1:0] lo1_reg [0:ncsn_pkg::NUM_GROUPS-1];
    logic signed [ncsn_pkg::SCORE_W-1:0] hi1_reg [0:ncsn_pkg::NUM_GROUPS-1];
    logic signed [ncsn_pkg::SCORE_W-1:0] lo1_next [0:ncsn_pkg::NUM_GROUPS-1];
    logic signed [ncsn_pkg::SCORE_W-1:0] hi1_next [0:ncsn_pkg::NUM_GROUPS-1];
    logic signed [ncsn_pkg::SCORE_W-1:0] lo2_reg, hi2_reg, lo2_next, hi2_next;
    ncsn_pkg::score_vec_t delta_reg, delta_next;

    // per-group min and max
    always_comb begin
        for (int g = 0; g < ncsn_pkg::NUM_GROUPS; g++) begin
            lo1_next[g] = $signed(scores[g * ncsn_pkg::GROUP_SIZE]);
            hi1_next[g] = $signed(scores[g * ncsn_pkg::GROUP_SIZE]);
            for (int m = 1; m < ncsn_pkg::GROUP_SIZE; m++) begin
                if ($signed(scores[g * ncsn_pkg::GROUP_SIZE + m]) < lo1_next[g]) begin
                    lo1_next[g] = $signed(scores[g * ncsn_pkg::GROUP_SIZE + m]);
                end
                if ($signed(scores[g * ncsn_pkg::GROUP_SIZE + m]) > hi1_next[g]) begin
                    hi1_next[g] = $signed(scores[g * ncsn_pkg::GROUP_SIZE + m]);
                end
            end
        end
    end

    // min and max over the groups
    always_comb begin
        lo2_next = lo1_reg[0];
        hi2_next = hi1_reg[0];
        for (int g = 1; g < ncsn_pkg::NUM_GROUPS; g++) begin
            if (lo1_reg[g] < lo2_next) begin
                lo2_next = lo1_reg[g];
            end
            if (hi1_reg[g] > hi2_next) begin
                hi2_next = hi1_reg[g];
            end
        end
    end

    // distance from min (plain mode) or to max (normalizing modes)
    always_comb begin
        for (int i = 0; i < ncsn_pkg::NUM_CLASSES; i++) begin
            if (mode == ncsn_pkg::MODE_PLAIN) begin
                delta_next[i] = ncsn_pkg::SCORE_W'(s2_reg[i] - lo2_reg);
            end else begin
                delta_next[i] = ncsn_pkg::SCORE_W'(hi2_reg - s2_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < ncsn_pkg::NUM_CLASSES; i++) begin
                s1_reg[i] <= $signed(scores[i]);
                s2_reg[i] <= s1_reg[i];
            end
            for (int g = 0; g < ncsn_pkg::NUM_GROUPS; g++) begin
                lo1_reg[g] <= lo1_next[g];
                hi1_reg[g] <= hi1_next[g];
            end
            lo2_reg   <= lo2_next;
            hi2_reg   <= hi2_next;
            delta_reg <= delta_next;
        end
    end

    assign delta = delta_reg;

endmodule

### rtl/core/ncsn_exp_lane.sv
module ncsn_exp_lane (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [ncsn_pkg::SCORE_W-1:0] delta,
    output logic [ncsn_pkg::E_W-1:0]     e
);

    localparam int T = ncsn_pkg::TAYLOR_TERMS;

    logic [ncsn_pkg::BIG_W-1:0]   big_next, big_reg;
    logic [ncsn_pkg::N_MAX:0]     ge;
    logic [ncsn_pkg::N_W-1:0]     n_next, n1_reg;
    logic                         zero1_reg;
    logic [ncsn_pkg::BIG_W-1:0]   r_full;

    logic [ncsn_pkg::SCORE_W-1:0] r_reg    [0:2*T-2];
    logic [ncsn_pkg::N_W-1:0]     n_reg    [0:2*T];
    logic                         zero_reg [0:2*T];
    logic [ncsn_pkg::E_W-1:0]     t_reg    [0:T];
    logic [ncsn_pkg::SCORE_W-1:0] p_reg    [0:T-1];
    logic [ncsn_pkg::E_W-1:0]     e_reg;

    // range reduction: count multiples of ln2 below the scaled distance
    always_comb begin
        big_next = {delta, (ncsn_pkg::SCORE_W - ncsn_pkg::FRAC_BITS)'(0)};
        ge[0] = 1'b1;
        for (int k = 1; k <= ncsn_pkg::N_MAX; k++) begin
            ge[k] = big_next >= ncsn_pkg::BIG_W'(k) * ncsn_pkg::BIG_W'(ncsn_pkg::LN2_Q32);
        end
        n_next = '0;
        for (int k = 0; k < ncsn_pkg::N_MAX; k++) begin
            if (ge[k] && !ge[k+1]) begin
                n_next = n_next | ncsn_pkg::N_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg   <= big_next;
            n1_reg    <= n_next;
            zero1_reg <= ge[ncsn_pkg::N_MAX];
        end
    end

    // remainder after removing n*ln2
    assign r_full = big_reg - ncsn_pkg::BIG_W'(n1_reg) * ncsn_pkg::BIG_W'(ncsn_pkg::LN2_Q32);

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= r_full[ncsn_pkg::SCORE_W-1:0];
            n_reg[0]    <= n1_reg;
            zero_reg[0] <= zero1_reg;
            t_reg[0]    <= ncsn_pkg::ONE_Q32;
        end
    end

    // horner taylor steps, a multiply stage then a divide-by-k stage per term
    for (genvar j = 0; j < T; j++) begin : g_term
        localparam int K = T - j;
        logic [ncsn_pkg::SCORE_W+ncsn_pkg::E_W-1:0] prod;
        logic [ncsn_pkg::SCORE_W+ncsn_pkg::RECIP_W-1:0] qprod;
        logic [ncsn_pkg::E_W-1:0] q;

        assign prod  = (ncsn_pkg::SCORE_W + ncsn_pkg::E_W)'(r_reg[2*j])
                     * (ncsn_pkg::SCORE_W + ncsn_pkg::E_W)'(t_reg[j]);
        assign qprod = (ncsn_pkg::SCORE_W + ncsn_pkg::RECIP_W)'(p_reg[j])
                     * (ncsn_pkg::SCORE_W + ncsn_pkg::RECIP_W)'(ncsn_pkg::recip_mult(K));
        assign q     = ncsn_pkg::E_W'(qprod >> ncsn_pkg::recip_shift(K));

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[j]        <= prod[2*ncsn_pkg::SCORE_W-1:ncsn_pkg::SCORE_W];
                n_reg[2*j+1]    <= n_reg[2*j];
                zero_reg[2*j+1] <= zero_reg[2*j];
                t_reg[j+1]      <= ncsn_pkg::ONE_Q32 - q;
                n_reg[2*j+2]    <= n_reg[2*j+1];
                zero_reg[2*j+2] <= zero_reg[2*j+1];
            end
        end

        if (j < T - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[2*j+1] <= r_reg[2*j];
                    r_reg[2*j+2] <= r_reg[2*j+1];
                end
            end
        end
    end

    // scale by 2^-n, underflow to zero
    always_ff @(posedge aclk) begin
        if (en) begin
            if (zero_reg[2*T]) begin
                e_reg <= '0;
            end else begin
                e_reg <= t_reg[T] >> n_reg[2*T];
            end
        end
    end

    assign e = e_reg;

endmodule

### rtl/core/ncsn_div_lane.sv
module ncsn_div_lane (
    input  logic                        aclk,
    input  logic                        en,
    input  ncsn_pkg::div_in_t           din,
    output logic [ncsn_pkg::NORM_W-1:0] norm
);

    localparam int Q = ncsn_pkg::NORM_W;

    logic [ncsn_pkg::NUM_W-1:0]  rem_reg [0:Q-1];
    logic [ncsn_pkg::DEN_W-1:0]  den_reg [0:Q-1];
    ncsn_pkg::sel_t              sel_reg [0:Q];
    logic [Q-1:0]                rnd_reg [0:Q];
    logic [Q-1:0]                quo_reg [1:Q];
    logic [Q-1:0]                norm_reg;
    logic [ncsn_pkg::NUM_W-1:0]  num_next;

    // rounded numerator: e scaled up plus half the denominator
    assign num_next = (ncsn_pkg::NUM_W'(din.e) << ncsn_pkg::FRAC_BITS)
                    + ncsn_pkg::NUM_W'(din.den >> 1);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_next;
            den_reg[0] <= din.den;
            sel_reg[0] <= din.sel;
            rnd_reg[0] <= din.rnd;
        end
    end

    // restoring division, one quotient bit per stage from the top
    for (genvar s = 0; s < Q; s++) begin : g_step
        localparam int B = Q - 1 - s;
        logic [ncsn_pkg::CMP_W-1:0] trial;
        logic                       fits;
        logic [Q-1:0]               quo_prev;

        assign trial = ncsn_pkg::CMP_W'(rem_reg[s])
                     - (ncsn_pkg::CMP_W'(den_reg[s]) << B);
        assign fits  = !trial[ncsn_pkg::CMP_W-1];

        if (s == 0) begin : g_first
            assign quo_prev = '0;
        end else begin : g_rest
            assign quo_prev = quo_reg[s];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[s+1] <= {quo_prev[Q-2:0], fits};
                sel_reg[s+1] <= sel_reg[s];
                rnd_reg[s+1] <= rnd_reg[s];
            end
        end

        if (s < Q - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s+1] <= fits ? trial[ncsn_pkg::NUM_W-1:0] : rem_reg[s];
                    den_reg[s+1] <= den_reg[s];
                end
            end
        end
    end

    // pick the result for the mode
    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (sel_reg[Q])
                ncsn_pkg::SEL_ROUND: norm_reg <= rnd_reg[Q];
                ncsn_pkg::SEL_DIV:   norm_reg <= quo_reg[Q];
                default:             norm_reg <= '0;
            endcase
        end
    end

    assign norm = norm_reg;

endmodule

### rtl/core/nine_class_score_normalizer.sv
// Nine-class score normalizer. Each request carries nine signed Q15.16 log
// scores and returns nine unsigned Q1.16 values (65536 is one). norm_mode 0
// gives exp(min - score), mode 1 the softmax share of each class, mode 2 the
// per-class share (exon classes 0..5 against themselves plus the shared
// classes 6..8, shared classes against the total); mode 3 returns zeros.
// The block is a fixed pipeline of 51 register stages: 3 for min/max and
// distances, 27 for the exponent (ln2 range reduction and twelve Taylor terms,
// each a multiply stage and a divide-by-k stage), 2 for the sums and 19 for
// the rounded restoring divider, one quotient bit per stage. It takes one
// request per cycle, and when the result at the output is not taken the
// whole pipeline holds. Write norm_mode only while no request is in
// flight.
module nine_class_score_normalizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // score_0 .. score_8, 32 bits each from the lowest bit up
    input  logic [ncsn_pkg::IN_W-1:0]     s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // norm_0 .. norm_8, 17 bits each from the lowest bit up, zero padded
    output logic [ncsn_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [1:0]                    cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);

    localparam int N      = ncsn_pkg::NUM_CLASSES;
    localparam int SUM_IX = ncsn_pkg::EXT_LAT + ncsn_pkg::EXP_LAT;

    ncsn_pkg::mode_t      mode_reg;
    ncsn_pkg::ctl_t       ctl_reg [0:ncsn_pkg::PIPE_LAT-1];
    logic                 en;
    ncsn_pkg::score_vec_t scores, delta;

    logic [ncsn_pkg::E_W-1:0]    e_w      [0:N-1];
    logic [ncsn_pkg::E_W-1:0]    e1_reg   [0:N-1];
    logic [ncsn_pkg::SUM3_W-1:0] part_reg [0:ncsn_pkg::NUM_GROUPS-1];
    logic [ncsn_pkg::SUM3_W-1:0] part_next [0:ncsn_pkg::NUM_GROUPS-1];
    logic [ncsn_pkg::DEN_W-1:0]  total;
    logic [ncsn_pkg::E_W:0]      rnd_sum  [0:N-1];
    ncsn_pkg::div_in_t           div_next [0:N-1];
    ncsn_pkg::div_in_t           div_reg  [0:N-1];
    logic [ncsn_pkg::NORM_W-1:0] norm_w   [0:N-1];

    // pipeline advances unless a finished result is held
    assign en        = !ctl_reg[ncsn_pkg::PIPE_LAT-1].valid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ncsn_pkg::MODE_PLAIN;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= ncsn_pkg::mode_t'(cfg_data);
        end
    end

    // valid and mode travel beside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < ncsn_pkg::PIPE_LAT; j++) begin
                ctl_reg[j] <= '{valid: 1'b0, mode: ncsn_pkg::MODE_PLAIN};
            end
        end else if (en) begin
            ctl_reg[0] <= '{valid: s_tvalid, mode: mode_reg};
            for (int j = 1; j < ncsn_pkg::PIPE_LAT; j++) begin
                ctl_reg[j] <= ctl_reg[j-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            scores[i] = s_tdata[i*ncsn_pkg::SCORE_W +: ncsn_pkg::SCORE_W];
        end
    end

    ncsn_extrema u_extrema (
        .aclk   (aclk),
        .en     (en),
        .mode   (ctl_reg[1].mode),
        .scores (scores),
        .delta  (delta)
    );

    for (genvar i = 0; i < N; i++) begin : g_exp
        ncsn_exp_lane u_exp (
            .aclk  (aclk),
            .en    (en),
            .delta (delta[i]),
            .e     (e_w[i])
        );
    end

    // group sums of the exponent terms
    always_comb begin
        for (int g = 0; g < ncsn_pkg::NUM_GROUPS; g++) begin
            part_next[g] = '0;
            for (int m = 0; m < ncsn_pkg::GROUP_SIZE; m++) begin
                part_next[g] = part_next[g]
                             + ncsn_pkg::SUM3_W'(e_w[g*ncsn_pkg::GROUP_SIZE + m]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < ncsn_pkg::NUM_GROUPS; g++) begin
                part_reg[g] <= part_next[g];
            end
            for (int i = 0; i < N; i++) begin
                e1_reg[i] <= e_w[i];
            end
        end
    end

    // denominators and result selection per class
    always_comb begin
        total = ncsn_pkg::DEN_W'(part_reg[0]) + ncsn_pkg::DEN_W'(part_reg[1])
              + ncsn_pkg::DEN_W'(part_reg[2]);
        for (int i = 0; i < N; i++) begin
            rnd_sum[i] = (ncsn_pkg::E_W + 1)'(e1_reg[i])
                       + ((ncsn_pkg::E_W + 1)'(1) << (31 - ncsn_pkg::FRAC_BITS));
            div_next[i].e   = e1_reg[i];
            div_next[i].rnd = ncsn_pkg::NORM_W'(rnd_sum[i] >> (32 - ncsn_pkg::FRAC_BITS));
            div_next[i].den = total;
            unique case (ctl_reg[SUM_IX].mode)
                ncsn_pkg::MODE_PLAIN:  div_next[i].sel = ncsn_pkg::SEL_ROUND;
                ncsn_pkg::MODE_SINGLE: div_next[i].sel = ncsn_pkg::SEL_DIV;
                ncsn_pkg::MODE_CLASS: begin
                    div_next[i].sel = ncsn_pkg::SEL_DIV;
                    if (i < ncsn_pkg::NUM_EXON) begin
                        div_next[i].den = ncsn_pkg::DEN_W'(e1_reg[i])
                                        + ncsn_pkg::DEN_W'(part_reg[2]);
                        if (div_next[i].den == '0) begin
                            div_next[i].sel = ncsn_pkg::SEL_ZERO;
                        end
                    end
                end
                default:               div_next[i].sel = ncsn_pkg::SEL_ZERO;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_div
        ncsn_div_lane u_div (
            .aclk (aclk),
            .en   (en),
            .din  (div_reg[i]),
            .norm (norm_w[i])
        );
    end

    // pack results, lowest class in the lowest bits
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < N; i++) begin
            m_tdata[i*ncsn_pkg::NORM_W +: ncsn_pkg::NORM_W] = norm_w[i];
        end
    end

    assign m_tvalid = ctl_reg[ncsn_pkg::PIPE_LAT-1].valid;

    // result checks used by the assertions
    ncsn_pkg::mode_t               out_mode;
    logic                          range_ok;
    logic                          any_one;
    logic [ncsn_pkg::NORM_W+3:0]   norm_total;

    assign out_mode = ctl_reg[ncsn_pkg::PIPE_LAT-1].mode;

    always_comb begin
        range_ok   = 1'b1;
        any_one    = 1'b0;
        norm_total = '0;
        for (int i = 0; i < N; i++) begin
            range_ok   = range_ok && (norm_w[i] <= ncsn_pkg::NORM_ONE);
            any_one    = any_one || (norm_w[i] == ncsn_pkg::NORM_ONE);
            norm_total = norm_total + (ncsn_pkg::NORM_W + 4)'(norm_w[i]);
        end
    end

`ifndef NO_ASSERTIONS
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> range_ok)
        else $error("result above one");

    a_plain_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_mode == ncsn_pkg::MODE_PLAIN) |-> any_one)
        else $error("plain mode without a class at one");

    a_single_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_mode == ncsn_pkg::MODE_SINGLE) |->
        (norm_total >= (ncsn_pkg::NORM_W + 4)'(ncsn_pkg::NORM_ONE) - 4
         && norm_total <= (ncsn_pkg::NORM_W + 4)'(ncsn_pkg::NORM_ONE) + 4))
        else $error("softmax shares do not sum to one");

    a_rsvd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_mode == ncsn_pkg::MODE_RSVD) |-> (m_tdata == '0))
        else $error("reserved mode result not zero");
`endif

endmodule
